// ----- src/pjw_hash_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the PJW string hash bucket block.
// No dependencies; imported by the controller, the datapath and the top level.
package pjw_hash_pkg;

   localparam int BYTE_W        = 8;
   localparam int HASH_W        = 32;
   localparam int SIZE_W        = 31;
   localparam int HASH_STEP_SH  = 4;
   localparam int HASH_FOLD_SH  = 24;
   localparam int DIV_STEPS     = HASH_W;
   localparam int CNT_W         = $clog2(DIV_STEPS);

   localparam logic [HASH_W-1:0] HASH_TOP_MASK    = 32'hF000_0000;
   localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = 31'd256;
   localparam logic [CNT_W-1:0]  CNT_LAST         = CNT_W'(DIV_STEPS - 1);

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_HOLD
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic hash_update;   // fold a nonzero byte into the running hash
      logic start_div;     // snapshot hash as dividend, clear hash
      logic div_step;      // one restoring-division step
      logic load_out;      // capture the bucket into the output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic byte_zero;     // the offered byte is the terminator
      logic last_step;     // the current division step is the final one
   } status_type;

   // One PJW hash step.
   function automatic logic [HASH_W-1:0] pjw_update(input logic [HASH_W-1:0] h,
                                                    input logic [BYTE_W-1:0] b);
      logic [HASH_W-1:0] t;
      logic [HASH_W-1:0] top;
      t   = (h << HASH_STEP_SH) + HASH_W'(b);
      top = t & HASH_TOP_MASK;
      return (t ^ (top >> HASH_FOLD_SH)) & ~HASH_TOP_MASK;
   endfunction

endpackage

// ----- src/pjw_hash_ctrl.sv -----
`timescale 1ns / 1ps
// Controller for the PJW hash bucket block: sequences the bucket reduction.
// Depends on pjw_hash_pkg.
module pjw_hash_ctrl
   import pjw_hash_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      req_xfer;

   // state register and result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // nonzero bytes always flow; a terminator waits until the divider is free
   assign req_ready = (state_ff == ST_IDLE) || !status.byte_zero;
   assign req_xfer  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in         = state_ff;
      cmd              = '0;
      cmd.hash_update  = req_xfer && !status.byte_zero;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer && status.byte_zero) begin
               cmd.start_div = 1'b1;
               state_in      = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.last_step) state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // no terminator is taken while a reduction is in flight
   a_no_term_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && status.byte_zero) |-> !req_ready)
      else $error("terminator accepted while divider busy");

   // a loaded result is presented next cycle
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid_ff)
      else $error("result loaded but not presented");

   // a finished result waits while the output register is occupied
   a_hold_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HOLD && rsp_valid_ff && !rsp_ready) |=> state_ff == ST_HOLD)
      else $error("result overwrote a pending transfer");

   // division always follows a start
   a_start_div: assert property (@(posedge clock) disable iff (reset)
      cmd.start_div |=> state_ff == ST_DIVIDE)
      else $error("start did not enter division");

endmodule

// ----- src/pjw_hash_dp.sv -----
`timescale 1ns / 1ps
// Datapath for the PJW hash bucket block: running hash, table size register,
// bit-serial restoring remainder unit and output register. Depends on pjw_hash_pkg.
module pjw_hash_dp
   import pjw_hash_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [BYTE_W-1:0] req_char_byte,
   input  logic              csr_write_en,
   input  logic [SIZE_W-1:0] csr_write_data,
   input  cmd_type           cmd,
   output status_type        status,
   output logic [SIZE_W-1:0] rsp_bucket
);

   logic [HASH_W-1:0] hash_ff, hash_in;
   logic [SIZE_W-1:0] size_ff;
   logic [HASH_W-1:0] dvd_ff, dvd_in;
   logic [SIZE_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SIZE_W-1:0] bucket_ff;
   logic [HASH_W-1:0] trial;
   logic [HASH_W-1:0] trial_sub;
   logic              trial_ge;

   // control state: hash, table size, step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= '0;
         size_ff <= TABLE_SIZE_RESET;
         cnt_ff  <= '0;
      end else begin
         hash_ff <= hash_in;
         cnt_ff  <= cnt_in;
         if (csr_write_en) size_ff <= csr_write_data;
      end
   end

   // divider payload and output register
   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      if (cmd.load_out) bucket_ff <= (size_ff == '0) ? '0 : rem_ff;
   end

   // running hash
   always_comb begin
      hash_in = hash_ff;
      if (cmd.start_div)        hash_in = '0;
      else if (cmd.hash_update) hash_in = pjw_update(hash_ff, req_char_byte);
   end

   // restoring remainder step: bring down one dividend bit
   assign trial     = {rem_ff, dvd_ff[HASH_W-1]};
   assign trial_ge  = trial >= {1'b0, size_ff};
   assign trial_sub = trial - {1'b0, size_ff};

   always_comb begin
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      if (cmd.start_div) begin
         dvd_in = hash_ff;
         rem_in = '0;
         cnt_in = '0;
      end else if (cmd.div_step) begin
         dvd_in = dvd_ff << 1;
         rem_in = trial_ge ? trial_sub[SIZE_W-1:0] : trial[SIZE_W-1:0];
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   assign status.byte_zero = (req_char_byte == '0);
   assign status.last_step = (cnt_ff == CNT_LAST);
   assign rsp_bucket       = bucket_ff;

endmodule

// ----- src/pjw_string_hash_bucket_top.sv -----
`timescale 1ns / 1ps
// PJW string hash bucket: one byte per transfer, one bucket per terminator.
// Nonzero bytes: one per cycle, also while a reduction is in flight.
// Terminator: the bit-serial remainder unit runs its 32 steps, then the bucket is loaded
// into the output register once that register is free; the next terminator waits for idle.
// Reset (synchronous, active high): hash cleared, table size 256, no result pending.
module pjw_string_hash_bucket_top
   import pjw_hash_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BYTE_W-1:0] req_char_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [SIZE_W-1:0] rsp_bucket,
   input  logic              csr_write_en,
   input  logic [SIZE_W-1:0] csr_write_data
);

   cmd_type    cmd;
   status_type status;

   // sequencing
   pjw_hash_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // hash, table size and remainder unit
   pjw_hash_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_char_byte  (req_char_byte),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .cmd            (cmd),
      .status         (status),
      .rsp_bucket     (rsp_bucket)
   );

endmodule
